// File: rtl/ssfp_pkg.sv
// ----------------------------------------------------------------------------
// ssfp_pkg: shared types and constants of the sensor-set frame parser
// Holds the phase, error and status codes, character constants, the
// configuration register indexes and the key-table lookup.
// ----------------------------------------------------------------------------
package ssfp_pkg;

    // Token buffer: a token may hold TOKEN_BUFFER-1 characters.
    localparam int TOKEN_BUFFER = 12;
    localparam int TOKEN_MAX    = TOKEN_BUFFER - 1;
    localparam int LEN_W        = $clog2(TOKEN_BUFFER);

    // Only the first four characters are ever compared against names.
    localparam int HELD   = 4;
    localparam int HELD_W = 2;

    // Numbers above this cap are illegal while they are being read.
    localparam logic [16:0] NUM_CAP = 17'd100000;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MASK     = 2'd0;
    localparam logic [1:0] CFG_INTERVAL = 2'd1;
    localparam logic [1:0] CFG_MIN      = 2'd2;
    localparam logic [1:0] CFG_MAX      = 2'd3;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_OPEN  = 8'h7B;
    localparam logic [7:0] CH_CLOSE = 8'h7D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef enum logic [1:0] {
        PH_OPEN,
        PH_BODY,
        PH_CLOSED
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_NO_OPEN,
        ERR_EMPTY,
        ERR_ILLEGAL,
        ERR_TOO_LONG,
        ERR_NO_CLOSE,
        ERR_TRAILING,
        ERR_MIXED
    } err_t;

    typedef enum logic [1:0] {
        ST_ACCEPTED,
        ST_QUERY,
        ST_REJECTED
    } status_t;

    typedef struct packed {
        status_t     status;
        err_t        err;
        logic [7:0]  mask;
        logic [15:0] interval;
    } result_t;

    // Space, tab, CR, LF, VT and FF count as whitespace.
    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A) ||
               (c == 8'h0B) || (c == 8'h0C);
    endfunction

    // Maps a key of one or two characters to its mask bit; zero when unknown.
    function automatic logic [7:0] key_bit(input logic [7:0] a, input logic [7:0] b,
                                           input logic [LEN_W-1:0] n);
        logic [7:0] m;
        logic       two;
        two  = (n == LEN_W'(2));
        m[0] = two && ({a, b} == "LW");
        m[1] = two && ({a, b} == "T1");
        m[2] = two && ({a, b} == "T2");
        m[3] = two && ({a, b} == "SM");
        m[4] = two && ({a, b} == "ST");
        m[5] = two && ({a, b} == "WS");
        m[6] = two && ({a, b} == "WD");
        m[7] = (n == LEN_W'(1)) && (a == "R");
        return m;
    endfunction

endpackage

// File: rtl/sensor_set_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// sensor_set_frame_parser_unit: byte-wide parser of sensor-set frames
// Scans a braced, comma-separated frame one byte per beat, folds each token
// into the selection and interval state as its separator arrives, and gives
// one result beat at the frame's last byte.
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------
//  input    | in_valid / in_stall   | text_byte[7:0], last_byte
//  result   | out_valid / out_stall | status[1:0], error_kind[2:0],
//           |                       | new_mask[7:0], new_interval[15:0]
//  config   | write_enable          | write_index[1:0], write_data[15:0]
//
//  One byte is taken every cycle while in_stall is low; token decode, number
//  accumulation and the final verdict are one pass of logic between the frame
//  state and the result register. A result register and a skid register sit on
//  the output; a frame's result goes to the skid register while the result
//  register still holds one, so in_stall rises only when both hold an untaken result.
//  Reset clears the frame state and the output valid flags, and sets the configuration registers to their defaults.
//
module sensor_set_frame_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  text_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [2:0]  error_kind,
    output logic [7:0]  new_mask,
    output logic [15:0] new_interval,
    input  logic        write_enable,
    input  logic [1:0]  write_index,
    input  logic [15:0] write_data
);

    localparam int LW = ssfp_pkg::LEN_W;

    // Configuration registers.
    logic [7:0]  cur_mask_reg;
    logic [15:0] cur_ivl_reg;
    logic [15:0] ivl_min_reg;
    logic [15:0] ivl_max_reg;

    // Frame state.
    ssfp_pkg::phase_t phase_reg, phase_next;
    ssfp_pkg::err_t   err_reg, err_next;
    logic [LW-1:0]    tok_len_reg, tok_len_next;
    logic [7:0]       tok_chars_reg [ssfp_pkg::HELD];
    logic [16:0]      num_reg, num_next;
    logic             num_bad_reg, num_bad_next;
    logic [7:0]       plain_reg, plain_next;
    logic [7:0]       add_reg, add_next;
    logic [7:0]       rem_reg, rem_next;
    logic             fplain_reg, fplain_next;
    logic             fint_reg, fint_next;
    logic             fquery_reg, fquery_next;
    logic [15:0]      ivl_seen_reg, ivl_seen_next;

    // Output registers.
    ssfp_pkg::result_t out_reg, skid_reg, result;
    logic              out_valid_reg, skid_valid_reg;

    logic accept, push, pop;
    logic chr_we;
    logic [7:0] cf;
    logic       cf_digit;
    logic [19:0] num_sum;

    // Token evaluation outputs.
    logic        tok_ok;
    logic [7:0]  tok_plain, tok_add, tok_rem;
    logic        tok_fplain, tok_fint, tok_fquery;
    logic [15:0] tok_ivl;

    assign accept   = in_valid && !in_stall;
    assign in_stall = skid_valid_reg;
    assign push     = accept && last_byte;
    assign pop      = out_valid_reg && !out_stall;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_mask_reg <= 8'd0;
            cur_ivl_reg  <= 16'd15;
            ivl_min_reg  <= 16'd1;
            ivl_max_reg  <= 16'd999;
        end
        else if (write_enable)
        begin
            unique case (write_index)
                ssfp_pkg::CFG_MASK:     cur_mask_reg <= write_data[7:0];
                ssfp_pkg::CFG_INTERVAL: cur_ivl_reg  <= write_data;
                ssfp_pkg::CFG_MIN:      ivl_min_reg  <= write_data;
                ssfp_pkg::CFG_MAX:      ivl_max_reg  <= write_data;
            endcase
        end
    end

    // Case folding and the next decimal step of the token.
    assign cf       = ((text_byte >= "a") && (text_byte <= "z")) ? text_byte - 8'd32
                                                               : text_byte;
    assign cf_digit = (cf >= "0") && (cf <= "9");
    assign num_sum  = {num_reg, 3'b000} + {2'b00, num_reg, 1'b0} + {16'd0, cf[3:0]};

    // Decode of the held token, giving the state after it is applied.
    always_comb
    begin
        logic [7:0] c0;
        logic [7:0] key_plain;
        logic [7:0] key_sign;
        logic       in_range;
        logic       conflict;
        c0        = tok_chars_reg[0];
        key_plain = ssfp_pkg::key_bit(tok_chars_reg[0], tok_chars_reg[1], tok_len_reg);
        key_sign  = ssfp_pkg::key_bit(tok_chars_reg[1], tok_chars_reg[2],
                                      tok_len_reg - LW'(1));
        in_range  = (num_reg >= {1'b0, ivl_min_reg}) && (num_reg <= {1'b0, ivl_max_reg});
        conflict  = fint_reg && (ivl_seen_reg != num_reg[15:0]);

        tok_ok     = 1'b0;
        tok_plain  = plain_reg;
        tok_add    = add_reg;
        tok_rem    = rem_reg;
        tok_fplain = fplain_reg;
        tok_fint   = fint_reg;
        tok_fquery = fquery_reg;
        tok_ivl    = ivl_seen_reg;

        priority if ((tok_len_reg == LW'(1)) && (c0 == ssfp_pkg::CH_QUERY))
        begin
            tok_ok     = 1'b1;
            tok_fquery = 1'b1;
        end
        else if ((c0 == ssfp_pkg::CH_PLUS) || (c0 == ssfp_pkg::CH_MINUS))
        begin
            tok_ok = (key_sign != 8'd0);
            if (c0 == ssfp_pkg::CH_PLUS)
                tok_add = add_reg | key_sign;
            else
                tok_rem = rem_reg | key_sign;
        end
        else if ((c0 >= "0") && (c0 <= "9"))
        begin
            tok_ok   = !num_bad_reg && in_range && !conflict;
            tok_ivl  = num_reg[15:0];
            tok_fint = 1'b1;
        end
        else if ((tok_len_reg == LW'(3)) &&
                 ({tok_chars_reg[0], tok_chars_reg[1], tok_chars_reg[2]} == "ALL"))
        begin
            tok_ok     = 1'b1;
            tok_plain  = 8'hFF;
            tok_fplain = 1'b1;
        end
        else if ((tok_len_reg == LW'(4)) &&
                 ({tok_chars_reg[0], tok_chars_reg[1], tok_chars_reg[2],
                   tok_chars_reg[3]} == "NONE"))
        begin
            tok_ok     = 1'b1;
            tok_fplain = 1'b1;
        end
        else
        begin
            tok_ok     = (key_plain != 8'd0);
            tok_plain  = plain_reg | key_plain;
            tok_fplain = 1'b1;
        end
    end

    // Byte scan: next frame state for the byte on the input.
    always_comb
    begin
        phase_next    = phase_reg;
        err_next      = err_reg;
        tok_len_next  = tok_len_reg;
        num_next      = num_reg;
        num_bad_next  = num_bad_reg;
        plain_next    = plain_reg;
        add_next      = add_reg;
        rem_next      = rem_reg;
        fplain_next   = fplain_reg;
        fint_next     = fint_reg;
        fquery_next   = fquery_reg;
        ivl_seen_next = ivl_seen_reg;
        chr_we        = 1'b0;

        if (err_reg == ssfp_pkg::ERR_NONE)
        begin
            unique case (phase_reg)
                ssfp_pkg::PH_OPEN:
                begin
                    if (!ssfp_pkg::is_space(text_byte))
                    begin
                        if (text_byte == ssfp_pkg::CH_OPEN)
                            phase_next = ssfp_pkg::PH_BODY;
                        else
                            err_next = ssfp_pkg::ERR_NO_OPEN;
                    end
                end
                ssfp_pkg::PH_BODY:
                begin
                    if (ssfp_pkg::is_space(text_byte))
                    begin
                        phase_next = phase_reg;
                    end
                    else if ((text_byte == ssfp_pkg::CH_COMMA) ||
                             (text_byte == ssfp_pkg::CH_CLOSE))
                    begin
                        if (tok_len_reg == LW'(0))
                            err_next = ssfp_pkg::ERR_EMPTY;
                        else if (!tok_ok)
                            err_next = ssfp_pkg::ERR_ILLEGAL;
                        else
                        begin
                            plain_next    = tok_plain;
                            add_next      = tok_add;
                            rem_next      = tok_rem;
                            fplain_next   = tok_fplain;
                            fint_next     = tok_fint;
                            fquery_next   = tok_fquery;
                            ivl_seen_next = tok_ivl;
                            tok_len_next  = LW'(0);
                            if (text_byte == ssfp_pkg::CH_CLOSE)
                                phase_next = ssfp_pkg::PH_CLOSED;
                        end
                    end
                    else if (tok_len_reg < LW'(ssfp_pkg::TOKEN_MAX))
                    begin
                        chr_we       = (tok_len_reg < LW'(ssfp_pkg::HELD));
                        tok_len_next = tok_len_reg + LW'(1);
                        if (tok_len_reg == LW'(0))
                        begin
                            num_next     = {13'd0, cf[3:0]};
                            num_bad_next = !cf_digit;
                        end
                        else if (!num_bad_reg)
                        begin
                            if (!cf_digit || (num_sum > {3'b000, ssfp_pkg::NUM_CAP}))
                                num_bad_next = 1'b1;
                            else
                                num_next = num_sum[16:0];
                        end
                    end
                    else
                    begin
                        err_next = ssfp_pkg::ERR_TOO_LONG;
                    end
                end
                ssfp_pkg::PH_CLOSED:
                begin
                    if (!ssfp_pkg::is_space(text_byte) && (text_byte != ssfp_pkg::CH_NUL))
                        err_next = ssfp_pkg::ERR_TRAILING;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Verdict of the frame, taken from the state after its last byte.
    always_comb
    begin
        ssfp_pkg::err_t e;
        logic [15:0]    clamped;
        logic [7:0]     base;
        e = err_next;
        if ((e == ssfp_pkg::ERR_NONE) && (phase_next == ssfp_pkg::PH_OPEN))
            e = ssfp_pkg::ERR_NO_OPEN;
        if ((e == ssfp_pkg::ERR_NONE) && (phase_next == ssfp_pkg::PH_BODY))
            e = ssfp_pkg::ERR_NO_CLOSE;

        if (cur_ivl_reg < ivl_min_reg)
            clamped = ivl_min_reg;
        else if (cur_ivl_reg > ivl_max_reg)
            clamped = ivl_max_reg;
        else
            clamped = cur_ivl_reg;

        base            = fplain_next ? plain_next : cur_mask_reg;
        result.status   = ssfp_pkg::ST_ACCEPTED;
        result.mask     = (base | add_next) & ~rem_next;
        result.interval = fint_next ? ivl_seen_next : clamped;

        if ((e == ssfp_pkg::ERR_NONE) && fquery_next)
        begin
            if (fplain_next || fint_next || (add_next != 8'd0) || (rem_next != 8'd0))
                e = ssfp_pkg::ERR_MIXED;
            result.status   = ssfp_pkg::ST_QUERY;
            result.mask     = cur_mask_reg;
            result.interval = clamped;
        end

        if (e != ssfp_pkg::ERR_NONE)
        begin
            result.status   = ssfp_pkg::ST_REJECTED;
            result.mask     = 8'd0;
            result.interval = 16'd0;
        end
        result.err = e;
    end

    // Frame state registers; the last byte returns them to the start state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= ssfp_pkg::PH_OPEN;
            err_reg      <= ssfp_pkg::ERR_NONE;
            tok_len_reg  <= LW'(0);
            num_reg      <= 17'd0;
            num_bad_reg  <= 1'b0;
            plain_reg    <= 8'd0;
            add_reg      <= 8'd0;
            rem_reg      <= 8'd0;
            fplain_reg   <= 1'b0;
            fint_reg     <= 1'b0;
            fquery_reg   <= 1'b0;
            ivl_seen_reg <= 16'd0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                phase_reg    <= ssfp_pkg::PH_OPEN;
                err_reg      <= ssfp_pkg::ERR_NONE;
                tok_len_reg  <= LW'(0);
                num_reg      <= 17'd0;
                num_bad_reg  <= 1'b0;
                plain_reg    <= 8'd0;
                add_reg      <= 8'd0;
                rem_reg      <= 8'd0;
                fplain_reg   <= 1'b0;
                fint_reg     <= 1'b0;
                fquery_reg   <= 1'b0;
                ivl_seen_reg <= 16'd0;
            end
            else
            begin
                phase_reg    <= phase_next;
                err_reg      <= err_next;
                tok_len_reg  <= tok_len_next;
                num_reg      <= num_next;
                num_bad_reg  <= num_bad_next;
                plain_reg    <= plain_next;
                add_reg      <= add_next;
                rem_reg      <= rem_next;
                fplain_reg   <= fplain_next;
                fint_reg     <= fint_next;
                fquery_reg   <= fquery_next;
                ivl_seen_reg <= ivl_seen_next;
            end
        end
    end

    // Leading token characters; read only below the token length.
    always_ff @(posedge clk)
    begin
        if (accept && chr_we)
            tok_chars_reg[tok_len_reg[ssfp_pkg::HELD_W-1:0]] <= cf;
    end

    // Output and skid valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                out_valid_reg <= 1'b0;
        end
    end

    // Output and skid payloads.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            if (out_valid_reg && !pop)
                skid_reg <= result;
            else
                out_reg <= result;
        end
        else if (pop && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_reg.status;
    assign error_kind   = out_reg.err;
    assign new_mask     = out_reg.mask;
    assign new_interval = out_reg.interval;

    // The skid register is only filled behind a waiting result.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while the output register is empty");

    // A rejected result carries an error code and no selection.
    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.status == ssfp_pkg::ST_REJECTED)) |->
        ((out_reg.err != ssfp_pkg::ERR_NONE) && (out_reg.mask == 8'd0) &&
         (out_reg.interval == 16'd0)))
        else $error("rejected result is not clean");

    // A result that is not rejected has no error code.
    a_pass_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.status != ssfp_pkg::ST_REJECTED)) |->
        (out_reg.err == ssfp_pkg::ERR_NONE))
        else $error("passing result carries an error code");

    // The token never grows beyond the buffer.
    a_token_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tok_len_reg <= LW'(ssfp_pkg::TOKEN_MAX))
        else $error("token length exceeds the buffer");

    // A byte that does not end a frame never produces a result beat.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && !push) |=> !out_valid_reg)
        else $error("result appeared without a last byte");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sensor_set_frame_parser_unit
// Feeds whole frames one byte per beat, predicts each frame's verdict from a
// byte-level scanner of its own, and compares every result beat field by field.
// Directed frames cover each error kind and token form; random frames run
// under changing register settings with idle bursts on both channels.
// ----------------------------------------------------------------------------
module testbench;

    localparam int STALL_LIMIT = 500;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  text_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [2:0]  error_kind;
    logic [7:0]  new_mask;
    logic [15:0] new_interval;
    logic        write_enable;
    logic [1:0]  write_index;
    logic [15:0] write_data;

    sensor_set_frame_parser_unit u_top (.*);

    // Key table: position in the table is the mask bit.
    string      key_name[8]    = '{"LW", "T1", "T2", "SM", "ST", "WS", "WD", "R"};
    logic [7:0] blank_chars[6] = '{8'h20, 8'h09, 8'h0D, 8'h0A, 8'h0B, 8'h0C};

    // Register shadows.
    logic [7:0]  cfg_mask;
    logic [15:0] cfg_interval;
    logic [15:0] cfg_min;
    logic [15:0] cfg_max;

    // Frame scanner state.
    ssfp_pkg::phase_t scan;
    logic [7:0]       tok_buf[ssfp_pkg::TOKEN_MAX];
    int               tok_len;
    logic [7:0]       sel_plain;
    logic [7:0]       sel_add;
    logic [7:0]       sel_del;
    logic             saw_plain;
    logic             saw_num;
    logic             saw_query;
    logic [15:0]      num_val;
    ssfp_pkg::err_t   fault;

    ssfp_pkg::result_t expected_verdicts[$];
    logic [7:0]        frame_q[$];
    longint            frame_number;

    logic        quiet;
    int          mismatch_count;
    int          bytes_sent;
    int          frames_sent;
    int          settings_count;
    int          n_accepted;
    int          n_query;
    int          n_rejected;
    logic [7:0]  err_seen;

    // Clock.
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Verdict predictor
    // ------------------------------------------------------------------------

    function automatic logic is_blank(logic [7:0] c);
        foreach (blank_chars[i])
            if (c == blank_chars[i]) return 1'b1;
        return 1'b0;
    endfunction

    function automatic void clear_frame();
        scan      = ssfp_pkg::PH_OPEN;
        tok_len   = 0;
        sel_plain = '0;
        sel_add   = '0;
        sel_del   = '0;
        saw_plain = 1'b0;
        saw_num   = 1'b0;
        saw_query = 1'b0;
        num_val   = '0;
        fault     = ssfp_pkg::ERR_NONE;
    endfunction

    function automatic logic [15:0] clamped_interval();
        if (cfg_interval < cfg_min) return cfg_min;
        if (cfg_interval > cfg_max) return cfg_max;
        return cfg_interval;
    endfunction

    // Mask bit of the key held at tok_buf[first +: count], zero when unknown.
    function automatic logic [7:0] sensor_bit(int first, int count);
        logic hit;
        for (int k = 0; k < 8; k++) begin
            if (key_name[k].len() == count) begin
                hit = 1'b1;
                for (int j = 0; j < count; j++)
                    if (tok_buf[first + j] != key_name[k][j]) hit = 1'b0;
                if (hit) return 8'(1 << k);
            end
        end
        return 8'h00;
    endfunction

    function automatic logic spelled(string s);
        if (tok_len != s.len()) return 1'b0;
        for (int j = 0; j < tok_len; j++)
            if (tok_buf[j] != s[j]) return 1'b0;
        return 1'b1;
    endfunction

    // Folds the held token into the frame state; zero when the token is illegal.
    function automatic logic fold_token();
        logic [7:0] lead;
        logic [7:0] hit;
        longint     val;
        lead = tok_buf[0];
        if (tok_len == 1 && lead == ssfp_pkg::CH_QUERY) begin
            saw_query = 1'b1;
            return 1'b1;
        end
        if (lead == ssfp_pkg::CH_PLUS || lead == ssfp_pkg::CH_MINUS) begin
            hit = sensor_bit(1, tok_len - 1);
            if (hit == 8'h00) return 1'b0;
            if (lead == ssfp_pkg::CH_PLUS) sel_add |= hit;
            else sel_del |= hit;
            return 1'b1;
        end
        if (lead >= "0" && lead <= "9") begin
            val = 0;
            for (int j = 0; j < tok_len; j++) begin
                if (tok_buf[j] < "0" || tok_buf[j] > "9") return 1'b0;
                val = val * 10 + longint'(tok_buf[j] - "0");
                if (val > ssfp_pkg::NUM_CAP) return 1'b0;
            end
            if (val < cfg_min || val > cfg_max) return 1'b0;
            if (saw_num && num_val != val) return 1'b0;
            num_val = val[15:0];
            saw_num = 1'b1;
            return 1'b1;
        end
        if (spelled("ALL")) begin
            sel_plain = 8'hFF;
            saw_plain = 1'b1;
            return 1'b1;
        end
        if (spelled("NONE")) begin
            saw_plain = 1'b1;
            return 1'b1;
        end
        hit = sensor_bit(0, tok_len);
        if (hit == 8'h00) return 1'b0;
        sel_plain |= hit;
        saw_plain = 1'b1;
        return 1'b1;
    endfunction

    // Advances the scanner by one byte; the first error sticks for the frame.
    function automatic void absorb_char(logic [7:0] c);
        if (fault != ssfp_pkg::ERR_NONE) return;
        case (scan)
            ssfp_pkg::PH_OPEN: begin
                if (!is_blank(c)) begin
                    if (c == ssfp_pkg::CH_OPEN) scan = ssfp_pkg::PH_BODY;
                    else fault = ssfp_pkg::ERR_NO_OPEN;
                end
            end
            ssfp_pkg::PH_BODY: begin
                if (is_blank(c)) return;
                if (c == ssfp_pkg::CH_COMMA || c == ssfp_pkg::CH_CLOSE) begin
                    if (tok_len == 0) fault = ssfp_pkg::ERR_EMPTY;
                    else if (!fold_token()) fault = ssfp_pkg::ERR_ILLEGAL;
                    else begin
                        tok_len = 0;
                        if (c == ssfp_pkg::CH_CLOSE) scan = ssfp_pkg::PH_CLOSED;
                    end
                end else if (tok_len < ssfp_pkg::TOKEN_MAX) begin
                    if (c >= "a" && c <= "z") c = c - 8'd32;
                    tok_buf[tok_len] = c;
                    tok_len++;
                end else begin
                    fault = ssfp_pkg::ERR_TOO_LONG;
                end
            end
            default: begin
                if (!is_blank(c) && c != ssfp_pkg::CH_NUL) fault = ssfp_pkg::ERR_TRAILING;
            end
        endcase
    endfunction

    // Verdict of the frame whose last byte has just been absorbed.
    function automatic ssfp_pkg::result_t frame_verdict();
        ssfp_pkg::result_t r;
        ssfp_pkg::err_t    e;
        logic [7:0]        base;
        e = fault;
        if (e == ssfp_pkg::ERR_NONE && scan == ssfp_pkg::PH_OPEN) e = ssfp_pkg::ERR_NO_OPEN;
        if (e == ssfp_pkg::ERR_NONE && scan == ssfp_pkg::PH_BODY) e = ssfp_pkg::ERR_NO_CLOSE;
        r.status   = ssfp_pkg::ST_ACCEPTED;
        r.mask     = '0;
        r.interval = '0;
        if (e == ssfp_pkg::ERR_NONE && saw_query) begin
            if (saw_plain || saw_num || sel_add != 8'h00 || sel_del != 8'h00) begin
                e = ssfp_pkg::ERR_MIXED;
            end else begin
                r.status   = ssfp_pkg::ST_QUERY;
                r.mask     = cfg_mask;
                r.interval = clamped_interval();
            end
        end else if (e == ssfp_pkg::ERR_NONE) begin
            base       = saw_plain ? sel_plain : cfg_mask;
            r.mask     = (base | sel_add) & ~sel_del;
            r.interval = saw_num ? num_val : clamped_interval();
        end
        if (e != ssfp_pkg::ERR_NONE) begin
            r.status   = ssfp_pkg::ST_REJECTED;
            r.mask     = '0;
            r.interval = '0;
        end
        r.err = e;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------

    // Sends one byte beat; called at a falling edge and returns at one.
    task automatic send_char(logic [7:0] c, logic fin);
        ssfp_pkg::result_t verdict;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        text_byte <= c;
        last_byte <= fin;
        do @(posedge clk); while (in_stall !== 1'b0);
        absorb_char(c);
        if (fin) begin
            verdict = frame_verdict();
            expected_verdicts.push_back(verdict);
            case (verdict.status)
                ssfp_pkg::ST_ACCEPTED: n_accepted++;
                ssfp_pkg::ST_QUERY:    n_query++;
                default:               n_rejected++;
            endcase
            err_seen[verdict.err] = 1'b1;
            clear_frame();
        end
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic add_byte(logic [7:0] b);
        frame_q.push_back(b);
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
    endtask

    // Sends the built frame, flagging its final byte.
    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++)
            send_char(frame_q[i], i == frame_q.size() - 1);
        frame_q.delete();
        frames_sent++;
    endtask

    // Holds the sender until every verdict has come back and the block is quiet.
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        while (expected_verdicts.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        write_enable <= 1'b1;
        write_index  <= idx;
        write_data   <= data;
        @(negedge clk);
        case (idx)
            ssfp_pkg::CFG_MASK:     cfg_mask     = data[7:0];
            ssfp_pkg::CFG_INTERVAL: cfg_interval = data;
            ssfp_pkg::CFG_MIN:      cfg_min      = data;
            default:                cfg_max      = data;
        endcase
    endtask

    task automatic load_settings(logic [15:0] mask, logic [15:0] ivl,
                                 logic [15:0] lo, logic [15:0] hi);
        pause_until_drained();
        write_reg(ssfp_pkg::CFG_MASK, mask);
        write_reg(ssfp_pkg::CFG_INTERVAL, ivl);
        write_reg(ssfp_pkg::CFG_MIN, lo);
        write_reg(ssfp_pkg::CFG_MAX, hi);
        write_enable <= 1'b0;
        settings_count++;
    endtask

    // ------------------------------------------------------------------------
    // Random frame builders
    // ------------------------------------------------------------------------

    function automatic logic [7:0] random_blank();
        return blank_chars[$urandom_range(0, 5)];
    endfunction

    // Pushes a word with random letter case and stray blanks between characters.
    task automatic put_word(string s);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if ($urandom_range(0, 7) == 0) add_byte(random_blank());
            if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1) c = c + 8'd32;
            add_byte(c);
        end
    endtask

    task automatic put_number(longint v);
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) add_byte("0");
        put_word($sformatf("%0d", v));
        frame_number = v;
    endtask

    task automatic put_token();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick <= 6) begin
            put_word(key_name[$urandom_range(0, 7)]);
        end else if (pick <= 9) begin
            add_byte($urandom_range(0, 1) ? ssfp_pkg::CH_PLUS : ssfp_pkg::CH_MINUS);
            put_word(key_name[$urandom_range(0, 7)]);
        end else if (pick == 10) begin
            put_word("ALL");
        end else if (pick == 11) begin
            put_word("NONE");
        end else if (pick <= 15) begin
            if (frame_number >= 0 && $urandom_range(0, 2) == 0) put_number(frame_number);
            else put_number($urandom_range(cfg_min, cfg_max));
        end else if (pick == 16) begin
            // Just outside the legal interval range.
            if ($urandom_range(0, 1)) put_number(longint'(cfg_min) - 1);
            else put_number(longint'(cfg_max) + 1);
        end else if (pick == 17) begin
            repeat ($urandom_range(1, 3)) add_byte(8'("A" + $urandom_range(0, 25)));
        end else if (pick == 18) begin
            put_word("?");
        end else begin
            repeat ($urandom_range(9, 13)) add_byte(8'("0" + $urandom_range(0, 42)));
        end
    endtask

    task automatic build_good_frame();
        int n;
        frame_number = -1;
        repeat ($urandom_range(0, 2)) add_byte(random_blank());
        add_byte(ssfp_pkg::CH_OPEN);
        if ($urandom_range(0, 9) == 0) begin
            put_word("?");
        end else begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
                if (i > 0) add_byte(ssfp_pkg::CH_COMMA);
                put_token();
            end
        end
        add_byte(ssfp_pkg::CH_CLOSE);
        repeat ($urandom_range(0, 2))
            add_byte($urandom_range(0, 3) == 0 ? ssfp_pkg::CH_NUL : random_blank());
    endtask

    // Noise, a corrupted byte, a cut-off frame, or text after the close.
    task automatic build_broken_frame();
        case ($urandom_range(0, 3))
            0: repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
            1: begin
                build_good_frame();
                frame_q[$urandom_range(0, frame_q.size() - 1)] = 8'($urandom_range(0, 255));
            end
            2: begin
                build_good_frame();
                repeat ($urandom_range(1, frame_q.size() - 1)) void'(frame_q.pop_back());
            end
            default: begin
                build_good_frame();
                add_byte(8'("!" + $urandom_range(0, 93)));
            end
        endcase
    endtask

    task automatic pick_random_settings();
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] ivl;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                lo = 16'($urandom_range(1, 40));
                hi = 16'($urandom_range(60, 2000));
            end
            6: begin
                lo = 16'($urandom_range(1, 65535));
                hi = lo;
            end
            7: begin
                lo = 16'($urandom_range(2, 65535));
                hi = 16'($urandom_range(1, lo - 1));
            end
            8: begin
                lo = 16'd1;
                hi = 16'hFFFF;
            end
            default: begin
                lo = 16'($urandom_range(1, 9));
                hi = 16'($urandom_range(lo, 99));
            end
        endcase
        if ($urandom_range(0, 1)) ivl = 16'($urandom_range(lo, hi));
        else ivl = 16'($urandom_range(0, 65535));
        load_settings(16'($urandom_range(0, 65535)), ivl, lo, hi);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_reset_settings();
        add_text("{?}");
        send_frame();
        add_text("{R}");
        send_frame();
    endtask

    task automatic test_error_codes();
        add_byte(8'hFF);
        send_frame();
        add_text(" \t");
        send_frame();
        add_text("{,R}");
        send_frame();
        add_text("{LX}");
        send_frame();
        add_text("{ABCDEFGHIJKL}");
        send_frame();
        add_text("{R");
        send_frame();
        add_text("{R}");
        add_byte(ssfp_pkg::CH_NUL);
        add_text("x");
        send_frame();
        add_text("{?,T1}");
        send_frame();
    endtask

    task automatic test_token_forms();
        add_text("{ all ,-r}");
        send_frame();
        add_text("{NONE,+t1,+T1}");
        send_frame();
        // A key given both signs ends up removed.
        add_text("{+ws,-WS}");
        send_frame();
        add_text("{lw,t2,sm,st,wd,R}");
        send_frame();
        add_text("{R");
        add_byte(ssfp_pkg::CH_NUL);
        add_text("}");
        send_frame();
        add_text("{+}");
        send_frame();
        add_text("{-ALL}");
        send_frame();
        add_text("{?}");
        add_byte(ssfp_pkg::CH_NUL);
        add_byte(ssfp_pkg::CH_NUL);
        send_frame();
    endtask

    task automatic test_interval_limits();
        add_text("{0999}");
        send_frame();
        add_text("{1000}");
        send_frame();
        add_text("{7,7}");
        send_frame();
        add_text("{7,8}");
        send_frame();
        add_text("{0}");
        send_frame();
        // Widest legal range, current interval below it.
        load_settings(16'hFFFF, 16'd0, 16'd1, 16'hFFFF);
        add_text("{65535}");
        send_frame();
        add_text("{65536}");
        send_frame();
        add_text("{99999999999}");
        send_frame();
        add_text("{?}");
        send_frame();
        // Inverted ranges, current interval at and below the minimum.
        load_settings(16'h005A, 16'hFFFF, 16'hFFFF, 16'd1);
        add_text("{?}");
        send_frame();
        add_text("{1}");
        send_frame();
        add_text("{R}");
        send_frame();
        load_settings(16'h0000, 16'd3, 16'd500, 16'd200);
        add_text("{+LW}");
        send_frame();
        // Single legal interval.
        load_settings(16'hA500, 16'd100, 16'd42, 16'd42);
        add_text("{42,ALL}");
        send_frame();
    endtask

    task automatic test_random_frames();
        int stop_at;
        stop_at = bytes_sent + 150;
        while (bytes_sent < stop_at) begin
            pick_random_settings();
            quiet = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(4, 10)) begin
                if ($urandom_range(0, 4) == 0) build_broken_frame();
                else build_good_frame();
                send_frame();
            end
        end
    endtask

    task automatic test_quiet_tail();
        load_settings(16'h00C3, 16'd15, 16'd1, 16'd999);
        quiet = 1'b1;
        repeat (6) begin
            build_good_frame();
            send_frame();
        end
    endtask

    // ------------------------------------------------------------------------
    // Result channel: random stall bursts, and the check of each beat
    // ------------------------------------------------------------------------

    initial begin : result_stall
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial begin : result_check
        ssfp_pkg::result_t want;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                if (expected_verdicts.size() == 0) begin
                    $error("result beat with no frame pending: status %0d, error_kind %0d",
                           status, error_kind);
                    mismatch_count++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        mismatch_count++;
                    end
                    if (error_kind !== want.err) begin
                        $error("error_kind: expected %0d, got %0d", want.err, error_kind);
                        mismatch_count++;
                    end
                    if (new_mask !== want.mask) begin
                        $error("new_mask: expected %0h, got %0h", want.mask, new_mask);
                        mismatch_count++;
                    end
                    if (new_interval !== want.interval) begin
                        $error("new_interval: expected %0d, got %0d",
                               want.interval, new_interval);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Watchdog: too long without any beat on either channel ends the run.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("[sensor_set_frame_parser_unit] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        text_byte      = 8'h00;
        last_byte      = 1'b0;
        write_enable   = 1'b0;
        write_index    = ssfp_pkg::CFG_MASK;
        write_data     = 16'h0000;
        quiet          = 1'b0;
        mismatch_count = 0;
        bytes_sent     = 0;
        frames_sent    = 0;
        settings_count = 1;
        n_accepted     = 0;
        n_query        = 0;
        n_rejected     = 0;
        err_seen       = '0;
        frame_number   = -1;
        cfg_mask       = 8'h00;
        cfg_interval   = 16'd15;
        cfg_min        = 16'd1;
        cfg_max        = 16'd999;
        clear_frame();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_settings();
        test_error_codes();
        test_token_forms();
        test_interval_limits();
        test_random_frames();
        test_quiet_tail();

        pause_until_drained();
        repeat (4) @(negedge clk);

        $display("Sent %0d frames (%0d byte beats) under %0d register settings.",
                 frames_sent, bytes_sent, settings_count);
        $display("Verdicts: %0d accepted, %0d query, %0d rejected; error kinds hit %b.",
                 n_accepted, n_query, n_rejected, err_seen);
        if (mismatch_count == 0 && expected_verdicts.size() == 0)
            $display("[sensor_set_frame_parser_unit] OK");
        else
            $display("[sensor_set_frame_parser_unit] ERROR");
        $finish;
    end

endmodule
